FILE: src/assert_macros.svh
// Assertion macros used by the port-level checker.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Assert an implication on every clock edge outside reset.
`define CHK_IMPL(label, clk, rstn, prop, msg) \
label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Assert an implication on every clock edge, reset included.
`define CHK_ALWAYS(label, clk, prop, msg) \
label: assert property (@(posedge clk) prop) else $error(msg);
`endif

FILE: src/tpve_pkg.sv
// Shared types and constants for the tri-axis period/volume estimator.
// No dependencies.
`default_nettype none
package tpve_pkg;
    localparam int SENSORS = 4;
    localparam int SAMPLES = 1024;
    localparam int SID_W = 2;
    localparam int IDX_W = $clog2(SAMPLES);
    localparam int CNT_W = IDX_W + 1;
    localparam int ADDR_W = $clog2(SENSORS * SAMPLES);
    localparam int AXES = 3;
    localparam int VOL_W = 26;
    localparam int AVG_W = 10;
    localparam int TOL_W = 10;
    localparam int VPC_W = 16;
    localparam int PER_W = IDX_W + 1;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_COMPUTE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE, ST_SCAN, ST_DRAIN, ST_SUM, ST_DIV, ST_OUT
    } state_t;

    // Merge stage phases: wait for start, average, divide.
    typedef enum logic [1:0] {
        MG_IDLE, MG_AVG, MG_DIV
    } merge_state_t;

    // Per-lane scan control from the sequencer.
    typedef struct packed {
        logic             start;
        logic             valid;
        logic [IDX_W-1:0] idx;
    } lane_ctl_t;

    // Per-lane outcome.
    typedef struct packed {
        logic             found;
        logic [PER_W-1:0] period;
    } lane_res_t;
endpackage
`default_nettype wire

FILE: src/tpve_lane.sv
// One axis lane: sample memory, running extremes and the peak-search scan.
// Depends on tpve_pkg.
`default_nettype none
module tpve_lane (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        wr_en,
    input  wire logic [tpve_pkg::ADDR_W-1:0] wr_addr,
    input  wire logic                        wr_first,
    input  wire logic signed [15:0]          wr_data,
    input  wire logic [tpve_pkg::SID_W-1:0]  rd_sid,
    input  wire logic [tpve_pkg::TOL_W-1:0]  tol,
    input  wire tpve_pkg::lane_ctl_t         ctl,
    output tpve_pkg::lane_res_t              res
);
    import tpve_pkg::*;

    logic signed [15:0] mem [SENSORS*SAMPLES];
    logic signed [15:0] min_reg [SENSORS];
    logic signed [15:0] max_reg [SENSORS];
    logic signed [15:0] rd_data_reg;
    logic               rd_valid_reg;
    logic [IDX_W-1:0]   rd_idx_reg;
    logic signed [15:0] lo_reg, hi_reg;
    logic [25:0]        tlo_reg, thi_reg;
    logic fmin1_reg, fmax1_reg, fmin2_reg, fmax2_reg;
    logic [IDX_W-1:0] pmin1_reg, pmax1_reg, pmin2_reg, pmax2_reg;
    logic [SID_W-1:0] wsid;
    logic [16:0] dlo, dhi, mlo, mhi;
    logic [26:0] dlo_k, dhi_k;
    logic nlo, nhi, f1a, f1b;
    logic fmin1_next, fmax1_next, fmin2_next, fmax2_next;
    logic [IDX_W-1:0] pmin1_next, pmax1_next, pmin2_next, pmax2_next;
    logic [IDX_W:0] dmax, dmin;

    assign wsid = wr_addr[ADDR_W-1 -: SID_W];

    // Store the sample and track extremes.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
            if (wr_first || wr_data < min_reg[wsid]) min_reg[wsid] <= wr_data;
            if (wr_first || wr_data > max_reg[wsid]) max_reg[wsid] <= wr_data;
        end
        rd_data_reg <= mem[{rd_sid, ctl.idx}];
        rd_idx_reg  <= ctl.idx;
    end

    // Latch the extremes and their tolerance products at scan start.
    always_comb begin
        mlo = min_reg[rd_sid][15] ? 17'(-$signed({min_reg[rd_sid][15], min_reg[rd_sid]}))
                                  : 17'({1'b0, min_reg[rd_sid]});
        mhi = max_reg[rd_sid][15] ? 17'(-$signed({max_reg[rd_sid][15], max_reg[rd_sid]}))
                                  : 17'({1'b0, max_reg[rd_sid]});
    end

    always_ff @(posedge aclk) begin
        if (ctl.start) begin
            lo_reg  <= min_reg[rd_sid];
            hi_reg  <= max_reg[rd_sid];
            tlo_reg <= 26'(mlo) * 26'(tol);
            thi_reg <= 26'(mhi) * 26'(tol);
        end
    end

    // Test the registered sample against both extremes.
    always_comb begin
        logic signed [16:0] a, b;
        a = 17'(rd_data_reg) - 17'(lo_reg);
        b = 17'(rd_data_reg) - 17'(hi_reg);
        dlo = a[16] ? 17'(-a) : 17'(a);
        dhi = b[16] ? 17'(-b) : 17'(b);
        dlo_k = 27'(dlo) * 27'd1000;
        dhi_k = dhi * 27'd1000;
        nlo = dlo_k < 27'(tlo_reg);
        nhi = dhi_k < 27'(thi_reg);
    end

    // Advance the peak search by one sample.
    always_comb begin
        fmin1_next = fmin1_reg; fmax1_next = fmax1_reg;
        fmin2_next = fmin2_reg; fmax2_next = fmax2_reg;
        pmin1_next = pmin1_reg; pmax1_next = pmax1_reg;
        pmin2_next = pmin2_reg; pmax2_next = pmax2_reg;
        f1a = 1'b0; f1b = 1'b0;
        if (rd_valid_reg) begin
            if (nlo && !fmin1_reg) begin
                fmin1_next = 1'b1; pmin1_next = rd_idx_reg;
            end
            if (nhi && !fmax1_reg) begin
                fmax1_next = 1'b1; pmax1_next = rd_idx_reg;
            end
            if (fmin1_next && fmax1_next) begin
                if (pmin1_next > pmax1_next) begin
                    f1a = nhi && !fmax2_reg && rd_idx_reg > pmin1_next;
                    if (f1a) begin
                        fmax2_next = 1'b1; pmax2_next = rd_idx_reg;
                    end
                    if (nlo && !fmin2_reg && fmax2_next && rd_idx_reg > pmax2_next) begin
                        fmin2_next = 1'b1; pmin2_next = rd_idx_reg;
                    end
                end else begin
                    f1b = nlo && !fmin2_reg && rd_idx_reg > pmax1_next;
                    if (f1b) begin
                        fmin2_next = 1'b1; pmin2_next = rd_idx_reg;
                    end
                    if (nhi && !fmax2_reg && fmin2_next && rd_idx_reg > pmin2_next) begin
                        fmax2_next = 1'b1; pmax2_next = rd_idx_reg;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || ctl.start) begin
            fmin1_reg <= 1'b0; fmax1_reg <= 1'b0;
            fmin2_reg <= 1'b0; fmax2_reg <= 1'b0;
        end else begin
            fmin1_reg <= fmin1_next; fmax1_reg <= fmax1_next;
            fmin2_reg <= fmin2_next; fmax2_reg <= fmax2_next;
        end
        // The first read of a scan is issued together with start.
        if (!aresetn) begin
            rd_valid_reg <= 1'b0;
        end else begin
            rd_valid_reg <= ctl.valid;
        end
        pmin1_reg <= pmin1_next; pmax1_reg <= pmax1_next;
        pmin2_reg <= pmin2_next; pmax2_reg <= pmax2_next;
    end

    assign dmax = {1'b0, pmax2_reg} - {1'b0, pmax1_reg};
    assign dmin = {1'b0, pmin2_reg} - {1'b0, pmin1_reg};
    assign res.found  = fmin1_reg && fmax1_reg && fmin2_reg && fmax2_reg;
    assign res.period = PER_W'(({1'b0, dmax} + {1'b0, dmin}) >> 1);
endmodule
`default_nettype wire

FILE: src/tpve_merge.sv
// Merge stage: average of lane periods and the iterative volume division.
// Depends on tpve_pkg.
`default_nettype none
module tpve_merge (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       start,
    input  wire tpve_pkg::lane_res_t        lane [tpve_pkg::AXES],
    input  wire logic [tpve_pkg::CNT_W-1:0] count,
    input  wire logic [tpve_pkg::VPC_W-1:0] vpc,
    output logic                            done,
    output logic [tpve_pkg::VOL_W-1:0]      volume,
    output logic [tpve_pkg::AVG_W-1:0]      avg,
    output logic                            bad
);
    import tpve_pkg::*;
    localparam int NUM_W = CNT_W + VPC_W;
    localparam int SUM_W = PER_W + 2;

    merge_state_t     phase_reg, phase_next;
    logic [SUM_W-1:0] sum_reg;
    logic [PER_W-1:0] avg_reg;
    logic [NUM_W-1:0] num_reg, quo_reg;
    logic [PER_W:0]   rem_reg;
    logic [$clog2(NUM_W+1)-1:0] bit_reg;
    logic             bad_reg;
    logic [PER_W:0]   trial;
    logic [SUM_W-1:0] q3;
    logic             div_end;

    assign trial = {rem_reg[PER_W-1:0], num_reg[NUM_W-1]};
    // Divide by three via reciprocal: exact for sums below 2^13.
    assign q3 = SUM_W'((32'(sum_reg) * 32'd43691) >> 17);
    assign div_end = bad_reg || bit_reg == ($bits(bit_reg))'(NUM_W);

    // Phase register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= MG_IDLE;
            done <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            done <= (phase_reg == MG_DIV) && div_end;
        end
    end

    // Next phase.
    always_comb begin
        phase_next = phase_reg;
        unique case (phase_reg)
            MG_IDLE: if (start) phase_next = MG_AVG;
            MG_AVG:  phase_next = MG_DIV;
            MG_DIV:  if (div_end) phase_next = MG_IDLE;
            default: phase_next = MG_IDLE;
        endcase
    end

    // Sum, average, then restoring division one quotient bit a cycle.
    always_ff @(posedge aclk) begin
        unique case (phase_reg)
            MG_IDLE: if (start) begin
                sum_reg <= SUM_W'(lane[0].period) + SUM_W'(lane[1].period)
                         + SUM_W'(lane[2].period);
                bad_reg <= !(lane[0].found && lane[1].found && lane[2].found);
                num_reg <= NUM_W'(count) * NUM_W'(vpc);
            end
            MG_AVG: begin
                avg_reg <= PER_W'(q3);
                if (q3 == '0) bad_reg <= 1'b1;
                rem_reg <= '0;
                quo_reg <= '0;
                bit_reg <= '0;
            end
            MG_DIV: if (!div_end) begin
                if (trial >= {1'b0, avg_reg}) begin
                    rem_reg <= trial - {1'b0, avg_reg};
                    quo_reg <= {quo_reg[NUM_W-2:0], 1'b1};
                end else begin
                    rem_reg <= trial;
                    quo_reg <= {quo_reg[NUM_W-2:0], 1'b0};
                end
                num_reg <= {num_reg[NUM_W-2:0], 1'b0};
                bit_reg <= bit_reg + 1'b1;
            end
            default: ;
        endcase
    end

    assign bad    = bad_reg;
    assign volume = bad_reg ? '0 : VOL_W'(quo_reg);
    assign avg    = bad_reg ? '0 : AVG_W'(avg_reg);
endmodule
`default_nettype wire

FILE: src/tri_axis_period_volume_estimator.sv
// Top level: handshake, config registers, scan sequencer, three lanes, merge.
// Depends on tpve_pkg, tpve_lane, tpve_merge.
// Loads are taken one per cycle while no compute request is in progress. A compute
// request scans the stored samples of its sensor one sample per cycle in the lanes,
// then runs a 27-step bit-serial divider. Reset is synchronous, active low: counts
// clear, registers return to 50 and 100; sample memories are not cleared.
`default_nettype none
module tri_axis_period_volume_estimator (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic                        s_func,
    input  wire logic [tpve_pkg::SID_W-1:0]  s_sensor_id,
    input  wire logic signed [15:0]          s_sample_x,
    input  wire logic signed [15:0]          s_sample_y,
    input  wire logic signed [15:0]          s_sample_z,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [tpve_pkg::VOL_W-1:0]       m_volume_milli,
    output logic [tpve_pkg::AVG_W-1:0]       m_average_period,
    output logic                             m_no_period,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [2:0]                  paddr,
    input  wire logic [31:0]                 pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);
    import tpve_pkg::*;
    localparam logic [2:0] ADDR_TOL = 3'd0;
    localparam logic [2:0] ADDR_VPC = 3'd4;

    logic [TOL_W-1:0] tol_reg;
    logic [VPC_W-1:0] vpc_reg;
    logic [CNT_W-1:0] count_reg [SENSORS];
    state_t state_reg, state_next;
    logic [SID_W-1:0] sid_reg;
    logic [CNT_W-1:0] n_reg, idx_reg, idx_next;
    logic [1:0] drain_reg, drain_next;
    lane_ctl_t ctl;
    lane_res_t res [AXES];
    logic s_acc, load_ok, scan_start, merge_start, merge_done;
    logic [VOL_W-1:0] vol;
    logic [AVG_W-1:0] avg;
    logic bad;
    logic signed [15:0] samp [AXES];

    // Register file.
    assign pready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tol_reg <= TOL_W'(50);
            vpc_reg <= VPC_W'(100);
        end else if (psel && penable && pwrite) begin
            unique case (paddr)
                ADDR_TOL: tol_reg <= pwdata[TOL_W-1:0];
                ADDR_VPC: vpc_reg <= pwdata[VPC_W-1:0];
                default: ;
            endcase
        end
    end
    always_comb begin
        unique case (paddr)
            ADDR_TOL: prdata = 32'(tol_reg);
            ADDR_VPC: prdata = 32'(vpc_reg);
            default:  prdata = '0;
        endcase
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign s_acc   = s_valid && s_ready;
    assign load_ok = s_acc && s_func == FUNC_LOAD
                     && count_reg[s_sensor_id] < CNT_W'(SAMPLES);

    // Per-sensor fill counts.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SENSORS; i++) count_reg[i] <= '0;
        end else if (load_ok) begin
            count_reg[s_sensor_id] <= count_reg[s_sensor_id] + 1'b1;
        end
    end

    // Sequencer state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            m_valid   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (m_valid && m_ready) m_valid <= 1'b0;
            if (merge_done) m_valid <= 1'b1;
        end
        idx_reg   <= idx_next;
        drain_reg <= drain_next;
        if (s_acc) begin
            sid_reg <= s_sensor_id;
            n_reg   <= count_reg[s_sensor_id];
        end
        if (merge_done) begin
            m_volume_milli   <= vol;
            m_average_period <= avg;
            m_no_period      <= bad;
        end
    end

    always_comb begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        drain_next  = drain_reg;
        scan_start  = 1'b0;
        merge_start = 1'b0;
        ctl.valid   = 1'b0;
        ctl.idx     = idx_reg[IDX_W-1:0];
        unique case (state_reg)
            ST_IDLE: if (s_acc && s_func == FUNC_COMPUTE) begin
                state_next = ST_SCAN;
                idx_next   = '0;
                ctl.idx    = '0;
            end
            ST_SCAN: begin
                if (idx_reg == '0) scan_start = 1'b1;
                if (idx_reg < n_reg) begin
                    ctl.valid = !scan_start || 1'b1;
                    idx_next  = idx_reg + 1'b1;
                end else begin
                    state_next = ST_DRAIN;
                    drain_next = 2'd0;
                end
            end
            ST_DRAIN: begin
                drain_next = drain_reg + 1'b1;
                if (drain_reg == 2'd2) state_next = ST_SUM;
            end
            ST_SUM: begin
                merge_start = 1'b1;
                state_next  = ST_DIV;
            end
            ST_DIV: if (merge_done) state_next = ST_OUT;
            ST_OUT: if (!m_valid || m_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
        ctl.start = scan_start;
    end

    assign samp[0] = s_sample_x;
    assign samp[1] = s_sample_y;
    assign samp[2] = s_sample_z;

    // Lanes, one per axis.
    for (genvar a = 0; a < AXES; a++) begin : g_lane
        tpve_lane u_lane (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .wr_en    (load_ok),
            .wr_addr  ({s_sensor_id, count_reg[s_sensor_id][IDX_W-1:0]}),
            .wr_first (count_reg[s_sensor_id] == '0),
            .wr_data  (samp[a]),
            .rd_sid   (sid_reg),
            .tol      (tol_reg),
            .ctl      (ctl),
            .res      (res[a])
        );
    end

    tpve_merge u_merge (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (merge_start),
        .lane    (res),
        .count   (n_reg),
        .vpc     (vpc_reg),
        .done    (merge_done),
        .volume  (vol),
        .avg     (avg),
        .bad     (bad)
    );
endmodule
`default_nettype wire

FILE: src/tpve_checker.sv
// Port-level checker for the estimator, bound to the top level.
// Depends on assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module tpve_checker (
    input wire logic aclk,
    input wire logic aresetn,
    input wire logic s_valid,
    input wire logic s_ready,
    input wire logic m_valid,
    input wire logic m_ready,
    input wire logic m_no_period,
    input wire logic [25:0] m_volume_milli,
    input wire logic [9:0]  m_average_period,
    input wire logic pready
);
    `CHK_ALWAYS(a_pready, aclk, pready, "pready low")
    `CHK_IMPL(a_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid, "result dropped")
    `CHK_IMPL(a_flag, aclk, aresetn, m_valid && m_no_period |-> m_volume_milli == 0 && m_average_period == 0, "flagged result nonzero")
    `CHK_IMPL(a_busy, aclk, aresetn, m_valid && !m_ready |-> !s_ready, "request taken while result pending")
endmodule
bind tri_axis_period_volume_estimator tpve_checker u_chk (.*);
`default_nettype wire

FILE: bench/tpve_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the tri-axis period/volume estimator: watches requests,
// register writes and results, predicts each result and compares it.
// Depends on tpve_pkg.
`default_nettype none
module tpve_scoreboard #(
    parameter logic [2:0] TOL_ADDR = 3'd0,
    parameter logic [2:0] VPC_ADDR = 3'd4
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_valid,
    input  wire logic                       s_ready,
    input  wire logic                       s_func,
    input  wire logic [tpve_pkg::SID_W-1:0] s_sensor_id,
    input  wire logic signed [15:0]         s_sample_x,
    input  wire logic signed [15:0]         s_sample_y,
    input  wire logic signed [15:0]         s_sample_z,
    input  wire logic                       m_valid,
    input  wire logic                       m_ready,
    input  wire logic [tpve_pkg::VOL_W-1:0] m_volume_milli,
    input  wire logic [tpve_pkg::AVG_W-1:0] m_average_period,
    input  wire logic                       m_no_period,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [2:0]                 paddr,
    input  wire logic [31:0]                pwdata,
    input  wire logic                       pready,
    output int                              pending,
    output int                              fail_count
);
    import tpve_pkg::*;

    typedef struct {
        logic [VOL_W-1:0] volume;
        logic [AVG_W-1:0] period;
        logic             no_period;
    } volume_est_t;

    volume_est_t est_q[$];

    logic [TOL_W-1:0] tol_pm;
    logic [VPC_W-1:0] vol_per_cycle;
    logic signed [15:0] mem_x [SENSORS*SAMPLES];
    logic signed [15:0] mem_y [SENSORS*SAMPLES];
    logic signed [15:0] mem_z [SENSORS*SAMPLES];
    int fill_level [SENSORS];
    int ch_lo [SENSORS][AXES];
    int ch_hi [SENSORS][AXES];

    assign pending = est_q.size();

    function automatic int sample_of(int axis, int idx);
        if (axis == 0) return mem_x[idx];
        if (axis == 1) return mem_y[idx];
        return mem_z[idx];
    endfunction

    // Closeness test in exact integers: 1000*|v-e| < tol*|e|.
    function automatic bit is_near(int v, int e);
        longint d, m;
        d = longint'(v) - longint'(e);
        if (d < 0) d = -d;
        m = (e < 0) ? -longint'(e) : longint'(e);
        return d * 1000 < longint'(tol_pm) * m;
    endfunction

    // Find the four peaks of one axis; return 1 and the period if all exist.
    function automatic bit axis_period(int s, int axis, output int per);
        int lo, hi, v, pmin1, pmax1, pmin2, pmax2;
        bit fmin1, fmax1, fmin2, fmax2, nlo, nhi;
        lo = ch_lo[s][axis];
        hi = ch_hi[s][axis];
        {fmin1, fmax1, fmin2, fmax2} = '0;
        {pmin1, pmax1, pmin2, pmax2} = '0;
        per = 0;
        for (int i = 0; i < fill_level[s]; i++) begin
            v = sample_of(axis, s * SAMPLES + i);
            nlo = is_near(v, lo);
            nhi = is_near(v, hi);
            if (nlo && !fmin1) begin
                fmin1 = 1; pmin1 = i;
            end
            if (nhi && !fmax1) begin
                fmax1 = 1; pmax1 = i;
            end
            if (!(fmin1 && fmax1)) continue;
            if (pmin1 > pmax1) begin
                // maximum came first: look for max, then min
                if (nhi && !fmax2 && i > pmin1) begin
                    fmax2 = 1; pmax2 = i;
                end
                if (nlo && !fmin2 && fmax2 && i > pmax2) begin
                    fmin2 = 1; pmin2 = i;
                end
            end else begin
                if (nlo && !fmin2 && i > pmax1) begin
                    fmin2 = 1; pmin2 = i;
                end
                if (nhi && !fmax2 && fmin2 && i > pmin2) begin
                    fmax2 = 1; pmax2 = i;
                end
            end
        end
        if (!(fmin1 && fmax1 && fmin2 && fmax2)) return 0;
        per = ((pmax2 - pmax1) + (pmin2 - pmin1)) / 2;
        return 1;
    endfunction

    function automatic volume_est_t estimate_volume(int s);
        volume_est_t r;
        int per, sum, avg;
        longint vol;
        r.volume = '0;
        r.period = '0;
        r.no_period = 1'b1;
        sum = 0;
        if (s >= SENSORS || fill_level[s] == 0) return r;
        for (int a = 0; a < AXES; a++) begin
            if (!axis_period(s, a, per)) return r;
            sum += per;
        end
        avg = sum / 3;
        if (avg == 0) return r;
        vol = longint'(fill_level[s]) * longint'(vol_per_cycle) / avg;
        r.volume = vol[VOL_W-1:0];
        r.period = avg[AVG_W-1:0];
        r.no_period = 1'b0;
        return r;
    endfunction

    always @(posedge aclk) begin
        int s, c, idx, v[AXES];
        volume_est_t exp_r;
        if (!aresetn) begin
            tol_pm <= 10'd50;
            vol_per_cycle <= 16'd100;
            fill_level = '{default: 0};
            est_q.delete();
        end else begin
            // register writes
            if (psel && penable && pwrite && pready) begin
                if (paddr == TOL_ADDR) tol_pm <= pwdata[TOL_W-1:0];
                else if (paddr == VPC_ADDR) vol_per_cycle <= pwdata[VPC_W-1:0];
            end
            // accepted requests
            if (s_valid && s_ready) begin
                s = s_sensor_id;
                if (s_func == FUNC_COMPUTE) begin
                    est_q.insert(est_q.size(), estimate_volume(s));
                end else if (s < SENSORS && fill_level[s] < SAMPLES) begin
                    c = fill_level[s];
                    idx = s * SAMPLES + c;
                    mem_x[idx] = s_sample_x;
                    mem_y[idx] = s_sample_y;
                    mem_z[idx] = s_sample_z;
                    v[0] = s_sample_x;
                    v[1] = s_sample_y;
                    v[2] = s_sample_z;
                    for (int a = 0; a < AXES; a++) begin
                        if (c == 0 || v[a] < ch_lo[s][a]) ch_lo[s][a] = v[a];
                        if (c == 0 || v[a] > ch_hi[s][a]) ch_hi[s][a] = v[a];
                    end
                    fill_level[s] = c + 1;
                end
            end
            // accepted results
            if (m_valid && m_ready) begin
                if (est_q.size() == 0) begin
                    $error("result with no request outstanding");
                    fail_count++;
                end else begin
                    exp_r = est_q.pop_front();
                    if (m_volume_milli !== exp_r.volume) begin
                        $error("volume_milli: expected %0d, got %0d",
                               exp_r.volume, m_volume_milli);
                        fail_count++;
                    end
                    if (m_average_period !== exp_r.period) begin
                        $error("average_period: expected %0d, got %0d",
                               exp_r.period, m_average_period);
                        fail_count++;
                    end
                    if (m_no_period !== exp_r.no_period) begin
                        $error("no_period: expected %0b, got %0b",
                               exp_r.no_period, m_no_period);
                        fail_count++;
                    end
                end
            end
        end
    end

    initial fail_count = 0;
endmodule
`default_nettype wire

FILE: bench/tri_axis_period_volume_estimator_tb.sv
`timescale 1ns / 1ps
// Top of the estimator regression: clock, reset, request and register stimulus,
// watchdog and verdict. Depends on tpve_pkg, tpve_scoreboard and the block.
`default_nettype none
module tri_axis_period_volume_estimator_tb;
    import tpve_pkg::*;

    localparam logic [2:0] TOL_ADDR = 3'd0;
    localparam logic [2:0] VPC_ADDR = 3'd4;
    localparam int STALL_LIMIT = 20000;
    localparam int HOLDOFF_CYCLES = 400;
    localparam int DRAIN_CYCLES = 40;

    logic aclk = 0, aresetn = 0;
    logic s_valid = 0, s_ready;
    logic s_func = FUNC_LOAD;
    logic [SID_W-1:0] s_sensor_id = '0;
    logic signed [15:0] s_sample_x = '0, s_sample_y = '0, s_sample_z = '0;
    logic m_valid, m_ready = 0, m_no_period;
    logic [VOL_W-1:0] m_volume_milli;
    logic [AVG_W-1:0] m_average_period;
    logic psel = 0, penable = 0, pwrite = 0, pready;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0, prdata;
    int pending, fail_count;

    int send_idle_pct, recv_idle_pct, items_sent;
    logic holdoff_go = 0;
    int holdoff_left = 0;
    int stall_cycles = 0;
    int loads_sent [SENSORS];

    tri_axis_period_volume_estimator dut (.*);

    tpve_scoreboard #(.TOL_ADDR(TOL_ADDR), .VPC_ADDR(VPC_ADDR)) checker_i (.*);

    always begin
        #10 aclk = 1;
        #10 aclk = 0;
    end

    // Receiver: random stalls, plus repeated long hold-offs while one is requested.
    always @(posedge aclk) begin
        if (holdoff_go && holdoff_left == 0) begin
            holdoff_left <= HOLDOFF_CYCLES;
            m_ready <= 1'b0;
        end else if (holdoff_left > 0) begin
            holdoff_left <= holdoff_left - 1;
            m_ready <= (holdoff_left == 1);
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog: end the run when nothing moves for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("tri_axis_period_volume_estimator regression: fail");
            $finish;
        end
    end

    // Idling mode follows progress through the run.
    always_comb begin
        if (items_sent < 700) begin
            send_idle_pct = 8; recv_idle_pct = 46;
        end else if (items_sent < 1400) begin
            send_idle_pct = 46; recv_idle_pct = 8;
        end else begin
            send_idle_pct = 0; recv_idle_pct = 0;
        end
    end

    task automatic send_request(logic fn, int sid, int x, int y, int z);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_func <= fn;
        s_sensor_id <= sid[SID_W-1:0];
        s_sample_x <= x[15:0];
        s_sample_y <= y[15:0];
        s_sample_z <= z[15:0];
        do @(posedge aclk); while (!s_ready);
        items_sent++;
        if (fn == FUNC_LOAD) loads_sent[sid]++;
    endtask

    task automatic write_reg(logic [2:0] addr, int value);
        s_valid <= 1'b0;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Hold until every result is back and loads have settled.
    task automatic wait_idle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Triangle wave in [-amp, amp] with the given period.
    function automatic int tri_wave(int i, int per, int amp);
        int ph;
        ph = i % per;
        if (2 * ph < per) return -amp + (4 * amp * ph) / per;
        return amp - (4 * amp * (ph - per / 2)) / per;
    endfunction

    // One burst of periodic samples with occasional random ones, maybe followed by a compute.
    task automatic send_wave_burst();
        int sid, len, per, ax, ay, az, off, nz;
        sid = $urandom_range(SENSORS - 1);
        len = $urandom_range(60, 8);
        per = $urandom_range(24, 4);
        ax = $urandom_range(30000, 50);
        ay = $urandom_range(30000, 50);
        az = $urandom_range(30000, 50);
        off = $urandom_range(per - 1);
        nz = $urandom_range(3);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(19) == 0)
                send_request(FUNC_LOAD, sid, $urandom, $urandom, $urandom);
            else
                send_request(FUNC_LOAD, sid,
                             tri_wave(i + off, per, ax) + $urandom_range(nz),
                             tri_wave(i + off, per, ay) - $urandom_range(nz),
                             tri_wave(i, per, az));
        end
        if ($urandom_range(9) < 7)
            send_request(FUNC_COMPUTE, sid, $urandom, $urandom, $urandom);
    endtask

    initial begin
        int tol_set [4] = '{1000, 0, 50, 1};
        int vpc_set [4] = '{65535, 0, 100, 1};
        loads_sent = '{default: 0};
        items_sent = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty sensor, full-scale values, short sweeps.
        send_request(FUNC_COMPUTE, 0, 0, 0, 0);
        send_request(FUNC_LOAD, 1, 32767, -32768, 0);
        send_request(FUNC_LOAD, 1, -32768, 32767, -1);
        send_request(FUNC_LOAD, 1, 0, 0, 1);
        send_request(FUNC_COMPUTE, 1, -1, -1, -1);
        for (int i = 0; i < 16; i++)
            send_request(FUNC_LOAD, 2, tri_wave(i, 4, 32767), tri_wave(i, 6, 1000),
                         tri_wave(i, 8, 20000));
        send_request(FUNC_COMPUTE, 2, 0, 0, 0);
        send_request(FUNC_COMPUTE, 3, 0, 0, 0);

        // Random bursts across register settings, extremes included.
        for (int ph = 0; ph < 5; ph++) begin
            wait_idle();
            if (ph < 4) begin
                write_reg(TOL_ADDR, tol_set[ph]);
                write_reg(VPC_ADDR, vpc_set[ph]);
            end else begin
                write_reg(TOL_ADDR, $urandom_range(300, 10));
                write_reg(VPC_ADDR, $urandom_range(65535));
            end
            if (ph == 2) holdoff_go <= 1'b1;
            while (items_sent < 300 * (ph + 1)) send_wave_burst();
            holdoff_go <= 1'b0;
        end

        // Fill one sensor past capacity so extra samples are dropped.
        while (loads_sent[3] < SAMPLES + 8)
            send_request(FUNC_LOAD, 3, $urandom, $urandom, $urandom);
        send_request(FUNC_COMPUTE, 3, 0, 0, 0);
        for (int s = 0; s < SENSORS; s++)
            send_request(FUNC_COMPUTE, s, 0, 0, 0);

        wait_idle();
        if (fail_count == 0)
            $display("tri_axis_period_volume_estimator regression: pass");
        else
            $display("tri_axis_period_volume_estimator regression: fail");
        $finish;
    end
endmodule
`default_nettype wire
